// ----- hw/rtl/serial_shell_line_editor_core_macros.svh -----
// Assertion macros for the serial shell line editor checker.
// Depends on nothing; included by the checker file only.
`ifndef SERIAL_SHELL_LINE_EDITOR_CORE_MACROS_SVH
`define SERIAL_SHELL_LINE_EDITOR_CORE_MACROS_SVH

// Same-cycle implication or any property written out by the caller.
`define SSLE_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("serial shell line editor assertion failed");

// Antecedent this cycle, consequent on the next clock edge.
`define SSLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("serial shell line editor assertion failed");

`endif

// ----- hw/rtl/ssle_pkg.sv -----
// Shared types and constants of the serial shell line editor.
// Depends on nothing; used by ssle_seq, the top level and the checker.
package ssle_pkg;

	localparam int LINE_LEN = 32;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// Register selects, taken from byte address bit 2
	localparam logic REG_ECHO = 1'b0;
	localparam logic REG_MASK = 1'b1;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	typedef enum logic [1:0] {
		K_ECHO = 2'd0,
		K_LINE = 2'd1,
		K_DONE = 2'd2,
		K_ESC  = 2'd3
	} ssle_kind_t;

	typedef struct packed {
		logic echo_enable;
		logic password_mask;
	} ssle_cfg_t;

	typedef struct packed {
		ssle_kind_t kind;
		logic [7:0] data_byte;
		logic [7:0] second_byte;
		logic [4:0] line_length;
		logic       last;
	} ssle_res_t;

endpackage

// ----- hw/rtl/ssle_rx_if.sv -----
// Input channel of the serial shell line editor: one received byte per transaction.
// Depends on nothing.
interface ssle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/ssle_res_if.sv -----
// Result channel of the serial shell line editor: one result item per transaction.
// Depends on nothing.
interface ssle_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] second_byte;
	logic [4:0] line_length;
	logic       last;

	modport source (output valid, output kind, output data_byte, output second_byte,
		output line_length, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input second_byte,
		input line_length, input last, output ready);
endinterface

// ----- hw/rtl/ssle_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ssle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/ssle_seq.sv -----
// Byte decoder and result sequencer of the serial shell line editor.
// Depends on ssle_pkg, ssle_rx_if, ssle_res_if and ssle_ram.
module ssle_seq #(
	parameter int LINE_LEN = ssle_pkg::LINE_LEN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssle_pkg::ssle_cfg_t cfg,
	ssle_rx_if.sink            rx,
	ssle_res_if.source         res
);

	localparam int IDX_W = $clog2(LINE_LEN);
	localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(LINE_LEN - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CR, ST_LF, ST_WALK, ST_DONE, ST_ESC,
		ST_BS1, ST_SP, ST_BS2, ST_CHAR
	} state_t;

	typedef enum logic [1:0] {
		ESC_IDLE, ESC_FIRST, ESC_SECOND
	} esc_phase_t;

	state_t              state_q;
	esc_phase_t          esc_phase_q;
	logic [7:0]          esc_first_q;
	logic [7:0]          esc_second_q;
	logic [7:0]          char_q;
	logic                job_line_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    len_q;
	logic [IDX_W-1:0]    idx_q;
	logic                res_valid_q;
	ssle_pkg::ssle_res_t res_q;

	logic             rx_fire;
	logic             slot_free;
	logic             res_load;
	logic             printable;
	logic [IDX_W-1:0] idx_nx;
	logic             more;
	logic [31:0]      len_ext;
	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;

	assign rx.ready  = (state_q == ST_IDLE);
	assign rx_fire   = rx.valid && rx.ready;
	assign slot_free = !res_valid_q || res.ready;
	// Every busy state loads a result as soon as the output slot frees up
	assign res_load  = slot_free && (state_q != ST_IDLE);
	assign printable = (rx.rx_byte >= ssle_pkg::CH_SPACE);
	assign idx_nx    = idx_q + IDX_W'(1);
	assign more      = (idx_nx != len_q);
	assign len_ext   = 32'(len_q);

	// Store writes only from idle, reads only in the LF and walk states: no same-entry overlap
	assign ram_we = rx_fire && (esc_phase_q == ESC_IDLE) && printable
		&& (rx.rx_byte != ssle_pkg::CH_CR) && (rx.rx_byte != ssle_pkg::CH_BS);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_nx;
		case (state_q)
			ST_LF: begin
				ram_re    = slot_free && job_line_q && (len_q != '0);
				ram_raddr = '0;
			end
			ST_WALK: begin
				ram_re = slot_free && more;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	ssle_ram #(
		.WIDTH (8),
		.DEPTH (LINE_LEN)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q),
		.wdata (rx.rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			esc_phase_q <= ESC_IDLE;
			esc_first_q <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res.ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rx_fire) begin
						if (esc_phase_q == ESC_FIRST) begin
							esc_first_q <= rx.rx_byte;
							esc_phase_q <= ESC_SECOND;
						end else if (esc_phase_q == ESC_SECOND) begin
							esc_second_q <= rx.rx_byte;
							esc_phase_q  <= ESC_IDLE;
							job_line_q   <= 1'b0;
							if (cfg.echo_enable) begin
								state_q <= ST_CR;
							end
						end else if (rx.rx_byte == ssle_pkg::CH_CR) begin
							len_q      <= cnt_q;
							cnt_q      <= '0;
							job_line_q <= 1'b1;
							if (cfg.echo_enable) begin
								state_q <= ST_CR;
							end
						end else if (rx.rx_byte == ssle_pkg::CH_BS) begin
							if (cnt_q != '0) begin
								cnt_q <= cnt_q - IDX_W'(1);
								if (cfg.echo_enable) begin
									state_q <= ST_BS1;
								end
							end
						end else if (printable) begin
							// Saturate at the last position: further bytes overwrite it
							if (cnt_q != CNT_MAX) begin
								cnt_q <= cnt_q + IDX_W'(1);
							end
							char_q <= cfg.password_mask ? ssle_pkg::CH_STAR : rx.rx_byte;
							if (cfg.echo_enable) begin
								state_q <= ST_CHAR;
							end
						end else if (rx.rx_byte == ssle_pkg::CH_ESC) begin
							esc_phase_q <= ESC_FIRST;
						end
					end
				end
				ST_CR: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_ECHO, ssle_pkg::CH_CR, 8'h00, 5'd0, 1'b0};
						state_q     <= ST_LF;
					end
				end
				ST_LF: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_ECHO, ssle_pkg::CH_LF, 8'h00, 5'd0, 1'b0};
						idx_q       <= '0;
						if (!job_line_q) begin
							state_q <= ST_ESC;
						end else if (len_q != '0) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_LINE, ram_rdata, 8'h00, 5'd0, 1'b0};
						idx_q       <= idx_nx;
						state_q     <= more ? ST_WALK : ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_DONE, 8'h00, 8'h00, len_ext[4:0], 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				ST_ESC: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_ESC, esc_first_q, esc_second_q, 5'd0, 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				ST_BS1: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_ECHO, ssle_pkg::CH_BS, 8'h00, 5'd0, 1'b0};
						state_q     <= ST_SP;
					end
				end
				ST_SP: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_ECHO, ssle_pkg::CH_SPACE, 8'h00, 5'd0, 1'b0};
						state_q     <= ST_BS2;
					end
				end
				ST_BS2: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_ECHO, ssle_pkg::CH_BS, 8'h00, 5'd0, 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				ST_CHAR: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_q       <= '{ssle_pkg::K_ECHO, char_q, 8'h00, 5'd0, 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = res_valid_q;
	assign res.kind        = res_q.kind;
	assign res.data_byte   = res_q.data_byte;
	assign res.second_byte = res_q.second_byte;
	assign res.line_length = res_q.line_length;
	assign res.last        = res_q.last;

endmodule

// ----- hw/rtl/serial_shell_line_editor_core.sv -----
// Top level of the serial shell line editor: APB register block and sequencer.
// Depends on ssle_pkg, ssle_rx_if, ssle_res_if, ssle_seq and ssle_ram.
//
// The block takes received serial bytes one transaction at a time and edits a
// command line held in a one-port-write, one-port-read RAM of LINE_LEN bytes.
// Printable bytes (0x20 and up, 0x7F..0xFF included) are written to the line
// and echoed, as '*' when password_mask is set; once LINE_LEN-1 characters
// are held, the last position is overwritten. Backspace drops the last
// character and echoes BS, space, BS; on an empty line it does nothing. ESC
// captures the next two bytes, whatever they are, and on the second one
// emits CR, LF and an escape result. Carriage return emits CR, LF, one line
// byte per stored character and a line-done result with the length, then
// clears the line. With echo_enable low the line and escape state still
// advance but no result is produced. Every byte's final result has last set.
// Register 0 (byte address 0) is echo_enable, register 1 (byte address 4)
// is password_mask, both in bit 0; both reset to zero. Rate: one byte is
// taken per transaction, and input ready is high only while the sequencer
// is idle, so a new byte is not taken until all results of the last one
// are loaded. Carriage return with echo emits one line result per stored
// character, the walk being paced by the RAM's registered read port, which
// is read one address ahead of the result being loaded. The final result
// sits in the output register while the next byte is accepted; a stalled
// result channel holds a busy sequencer in its state. No clearing pass is
// needed after reset.
module serial_shell_line_editor_core #(
	parameter int LINE_LEN = ssle_pkg::LINE_LEN
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssle_pkg::ADDR_W-1:0] paddr,
	input  logic [ssle_pkg::DATA_W-1:0] pwdata,
	output logic [ssle_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	ssle_rx_if.sink                     rx,
	ssle_res_if.source                  res
);

	ssle_pkg::ssle_cfg_t cfg_q;
	logic                cfg_wr;

	// Never wait-state the register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register select is byte address bit 2; other address bits alias
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				ssle_pkg::REG_ECHO: begin
					cfg_q.echo_enable <= pwdata[0];
				end
				ssle_pkg::REG_MASK: begin
					cfg_q.password_mask <= pwdata[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ssle_pkg::REG_ECHO: begin
				prdata = {{(ssle_pkg::DATA_W-1){1'b0}}, cfg_q.echo_enable};
			end
			ssle_pkg::REG_MASK: begin
				prdata = {{(ssle_pkg::DATA_W-1){1'b0}}, cfg_q.password_mask};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Decode bytes, hold the line state and sequence the results
	ssle_seq #(
		.LINE_LEN (LINE_LEN)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.rx     (rx),
		.res    (res)
	);

endmodule

// ----- hw/rtl/ssle_checker.sv -----
// Port-level checker of the serial shell line editor, bound to the top level.
// Depends on ssle_pkg and serial_shell_line_editor_core_macros.svh.
`include "serial_shell_line_editor_core_macros.svh"

module ssle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [7:0] res_data_byte,
	input logic [7:0] res_second_byte,
	input logic       res_last
);

	// A stalled result keeps its payload
	`SSLE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_data_byte) && $stable(res_last))

	// No new byte is taken before the current one has its final result queued
	`SSLE_ASSERT(a_busy_until_last, clk, arst_n, res_valid && !res_last |-> !rx_ready)

	// Line-done and escape results always close a byte's results
	`SSLE_ASSERT(a_tail_last, clk, arst_n, res_valid && (res_kind == ssle_pkg::K_DONE || res_kind == ssle_pkg::K_ESC) |-> res_last)

	// A line byte never has last set, so it never closes a byte's results
	`SSLE_ASSERT(a_line_not_last, clk, arst_n, res_valid && res_kind == ssle_pkg::K_LINE |-> !res_last)

	// Only escape results carry a second byte
	`SSLE_ASSERT(a_second_zero, clk, arst_n, res_valid && res_kind != ssle_pkg::K_ESC |-> res_second_byte == 8'h00)

endmodule

bind serial_shell_line_editor_core ssle_checker u_ssle_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_ready        (rx.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_kind        (res.kind),
	.res_data_byte   (res.data_byte),
	.res_second_byte (res.second_byte),
	.res_last        (res.last)
);
